/* hw/rtl/cdq_pkg.sv */
// Package for the circular deque core: sizes, operation and status codes,
// and the packed transaction and per-cell command types. No dependencies.
`default_nettype none

package cdq_pkg;

  localparam int unsigned Depth      = 16;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned CountWidth = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    OpPushBack  = 2'd0,
    OpPushFront = 2'd1,
    OpPopBack   = 2'd2,
    OpPopFront  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusUnderflow = 2'd1,
    StatusOverflow  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] data_in;
  } cdq_in_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    status_e            status;
    logic [4:0]         count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } cdq_out_t;

  // Enables broadcast to every cell; at most one is set, already gated by full/empty.
  typedef struct packed {
    logic ins_back;
    logic ins_front;
    logic rem_back;
    logic rem_front;
  } cdq_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/circular_deque_core.sv */
// Circular deque core: a chain of cdq_cell instances holding the deque in order,
// front at cell 0. Depends on cdq_pkg and cdq_cell.
// Result: the result strobe is registered and rises in the cycle after the start transaction.
// Throughput: one transaction per cycle; busy is never raised and the receiver cannot stall.
// Reset: asynchronous, active low; clears all occupied flags, the count and the
// result strobe, leaving an empty deque. Stored element data is not reset.
`default_nettype none

module circular_deque_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire cdq_pkg::cdq_in_t in_i,
  output logic                  result_valid_o,
  output cdq_pkg::cdq_out_t     result_o
);

  localparam int unsigned Depth = cdq_pkg::Depth;
  localparam int unsigned DW    = cdq_pkg::DataWidth;
  localparam int unsigned CW    = cdq_pkg::CountWidth;

  // Cell storage views: current and next contents of every cell.
  logic [DW-1:0] cell_data   [Depth];
  logic [DW-1:0] cell_data_d [Depth];
  logic [Depth-1:0] cell_valid, cell_valid_d;

  // Neighbor hookup: cell 0 sees the incoming element as an occupied left
  // neighbor, the last cell sees an empty right neighbor.
  logic [DW-1:0] left_data  [Depth];
  logic [DW-1:0] right_data [Depth];
  logic [Depth-1:0] left_valid, right_valid;

  logic [DW-1:0] push_data;
  logic          accept;
  logic          empty, full;
  cdq_pkg::cdq_cmd_t cmd;
  cdq_pkg::status_e  status;

  logic [CW-1:0] count_q, count_d;
  logic          result_valid_q;
  cdq_pkg::cdq_out_t result_q, result_d;

  logic [DW-1:0] back_now, back_next, front_next, popped;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign push_data = DW'(in_i.data_in);
  assign empty     = !cell_valid[0];
  assign full      = cell_valid[Depth-1];

  // Decode the operation and gate it against full/empty.
  always_comb begin
    cmd    = '0;
    status = cdq_pkg::StatusOk;
    case (in_i.op)
      cdq_pkg::OpPushBack: begin
        if (full) status = cdq_pkg::StatusOverflow;
        else      cmd.ins_back = accept;
      end
      cdq_pkg::OpPushFront: begin
        if (full) status = cdq_pkg::StatusOverflow;
        else      cmd.ins_front = accept;
      end
      cdq_pkg::OpPopBack: begin
        if (empty) status = cdq_pkg::StatusUnderflow;
        else       cmd.rem_back = accept;
      end
      cdq_pkg::OpPopFront: begin
        if (empty) status = cdq_pkg::StatusUnderflow;
        else       cmd.rem_front = accept;
      end
      default: begin
        status = cdq_pkg::StatusOk;
      end
    endcase
  end

  // Build the chain.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_data[i]  = push_data;
      assign left_valid[i] = 1'b1;
    end else begin : g_body
      assign left_data[i]  = cell_data[i-1];
      assign left_valid[i] = cell_valid[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign right_data[i]  = '0;
      assign right_valid[i] = 1'b0;
    end else begin : g_inner
      assign right_data[i]  = cell_data[i+1];
      assign right_valid[i] = cell_valid[i+1];
    end

    cdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .push_data_i  (push_data),
      .left_data_i  (left_data[i]),
      .left_valid_i (left_valid[i]),
      .right_data_i (right_data[i]),
      .right_valid_i(right_valid[i]),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i]),
      .data_d_o     (cell_data_d[i]),
      .valid_d_o    (cell_valid_d[i])
    );
  end

  // Back element = the occupied cell whose right neighbor is empty. The
  // occupied flags always form a prefix, so at most one cell matches; an
  // empty deque yields zero. Select on both current and next contents.
  always_comb begin
    back_now  = '0;
    back_next = '0;
    for (int unsigned i = 0; i < Depth; i++) begin
      if (cell_valid[i] && (i == Depth - 1 || !cell_valid[(i+1) % Depth]))
        back_now = back_now | cell_data[i];
      if (cell_valid_d[i] && (i == Depth - 1 || !cell_valid_d[(i+1) % Depth]))
        back_next = back_next | cell_data_d[i];
    end
  end

  assign front_next = cell_valid_d[0] ? cell_data_d[0] : '0;

  always_comb begin
    popped = '0;
    if (cmd.rem_front) popped = cell_data[0];
    else if (cmd.rem_back) popped = back_now;
  end

  // Track the element count alongside the chain.
  always_comb begin
    count_d = count_q;
    if (cmd.ins_back || cmd.ins_front) count_d = count_q + CW'(1);
    else if (cmd.rem_back || cmd.rem_front) count_d = count_q - CW'(1);
  end

  // Assemble the result transaction from the post-operation contents.
  always_comb begin
    result_d             = result_q;
    result_d.data_out    = 32'(popped);
    result_d.status      = status;
    result_d.count       = 5'(count_d);
    result_d.front_value = 32'(front_next);
    result_d.back_value  = 32'(back_next);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      count_q        <= count_d;
      result_valid_q <= accept;
    end
  end

  // Hold the result payload except on an accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire

/* hw/rtl/cdq_cell.sv */
// One storage cell of the deque chain: an element and its occupied flag.
// Depends on cdq_pkg for the data width and the command struct.
`default_nettype none

module cdq_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cdq_pkg::cdq_cmd_t             cmd_i,
  input  wire logic [cdq_pkg::DataWidth-1:0] push_data_i,
  input  wire logic [cdq_pkg::DataWidth-1:0] left_data_i,
  input  wire logic                          left_valid_i,
  input  wire logic [cdq_pkg::DataWidth-1:0] right_data_i,
  input  wire logic                          right_valid_i,
  output logic      [cdq_pkg::DataWidth-1:0] data_o,
  output logic                               valid_o,
  output logic      [cdq_pkg::DataWidth-1:0] data_d_o,
  output logic                               valid_d_o
);

  logic [cdq_pkg::DataWidth-1:0] data_q, data_d;
  logic                          valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (cmd_i.ins_front) begin
      // shift toward the back
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end else if (cmd_i.rem_front) begin
      // shift toward the front
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (cmd_i.ins_back && left_valid_i && !valid_q) begin
      // first free cell takes the new element
      data_d  = push_data_i;
      valid_d = 1'b1;
    end else if (cmd_i.rem_back && valid_q && !right_valid_i) begin
      // last occupied cell drops its element
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o    = data_q;
  assign valid_o   = valid_q;
  assign data_d_o  = data_d;
  assign valid_d_o = valid_d;

endmodule

`default_nettype wire
